FILE: rtl/obr_pkg.sv
// Shared types and constants for the overwriting byte ring buffer.
// Used by obr_ctrl, obr_dpath and overwriting_byte_ring_buffer; no dependencies.
`default_nettype none

package obr_pkg;

	localparam int MODE_W  = 2;
	localparam int BYTE_W  = 8;
	localparam int SRC_W   = 16;
	localparam int LIMIT_W = 7;
	localparam int LOST_W  = 32;

	typedef enum logic [MODE_W-1:0] {
		MODE_WRITE = 2'd0,
		MODE_READ  = 2'd1,
		MODE_CLEAR = 2'd2
	} mode_t;

	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_READ = 1'b1
	} state_t;

	typedef struct packed {
		logic do_write;
		logic do_clear;
		logic do_read_start;
		logic do_empty;
		logic do_issue;
	} cmd_t;

	typedef struct packed {
		logic fill_zero;
		logic rem_last;
	} sts_t;

endpackage

`default_nettype wire

FILE: rtl/obr_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module obr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

FILE: rtl/obr_ctrl.sv
// Controller state machine of the byte ring buffer: decodes items, sequences reads.
// Depends on obr_pkg.
`default_nettype none

module obr_ctrl (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	input  wire logic [obr_pkg::MODE_W-1:0]   mode,
	input  wire obr_pkg::sts_t                sts,
	output obr_pkg::cmd_t                     cmd,
	output logic                              busy
);

	obr_pkg::state_t state_q;
	obr_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= obr_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			obr_pkg::ST_IDLE: begin
				if (start && mode == obr_pkg::MODE_READ && !sts.fill_zero) begin
					state_d = obr_pkg::ST_READ;
				end
			end
			obr_pkg::ST_READ: begin
				if (sts.rem_last) begin
					state_d = obr_pkg::ST_IDLE;
				end
			end
			default: state_d = obr_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd  = '0;
		busy = 1'b0;
		unique case (state_q)
			obr_pkg::ST_IDLE: begin
				if (start) begin
					unique case (mode)
						obr_pkg::MODE_WRITE: cmd.do_write = 1'b1;
						obr_pkg::MODE_CLEAR: cmd.do_clear = 1'b1;
						obr_pkg::MODE_READ: begin
							if (sts.fill_zero) begin
								cmd.do_empty = 1'b1;
							end else begin
								cmd.do_read_start = 1'b1;
							end
						end
						default: cmd = '0;
					endcase
				end
			end
			obr_pkg::ST_READ: begin
				busy         = 1'b1;
				cmd.do_issue = 1'b1;
			end
			default: busy = 1'b0;
		endcase
	end

endmodule

`default_nettype wire

FILE: rtl/obr_dpath.sv
// Datapath of the byte ring buffer: pointers, fill level, lost counter, result stage.
// Depends on obr_pkg and obr_ram.
`default_nettype none

module obr_dpath #(
	parameter int CAPACITY = 4096,
	parameter int MAX_READ = 64
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire obr_pkg::cmd_t                 cmd,
	input  wire logic [obr_pkg::BYTE_W-1:0]    write_byte,
	input  wire logic [obr_pkg::SRC_W-1:0]     source_lost,
	input  wire logic [obr_pkg::LIMIT_W-1:0]   read_limit,
	output obr_pkg::sts_t                      sts,
	output logic                               strobe,
	output logic [obr_pkg::BYTE_W-1:0]         read_byte,
	output logic                               byte_valid,
	output logic [obr_pkg::LOST_W-1:0]         dropped_count,
	output logic                               last
);

	localparam int AW = $clog2(CAPACITY);
	localparam int FW = AW + 1;
	localparam int LW = obr_pkg::LIMIT_W;
	localparam logic [FW-1:0] CAP_FILL = FW'(CAPACITY);
	localparam logic [LW-1:0] MAX_LIM  = LW'(MAX_READ);

	logic [AW-1:0]                 wp_q;
	logic [FW-1:0]                 fill_q;
	logic [obr_pkg::LOST_W-1:0]    lost_q;
	logic [AW-1:0]                 rd_pos_q;
	logic [LW-1:0]                 rem_q;
	logic [obr_pkg::LOST_W-1:0]    snap_q;
	logic                          valid_s1;
	logic                          byte_s1;
	logic                          last_s1;
	logic [obr_pkg::BYTE_W-1:0]    rdata;
	logic                          full;
	logic [LW-1:0]                 lim;
	logic [LW-1:0]                 n;

	assign full = (fill_q == CAP_FILL);

	always_comb begin
		priority if (read_limit == '0) begin
			lim = LW'(1);
		end else if (read_limit > MAX_LIM) begin
			lim = MAX_LIM;
		end else begin
			lim = read_limit;
		end
		n = (fill_q < FW'(lim)) ? fill_q[LW-1:0] : lim;
	end

	assign sts.fill_zero = (fill_q == '0);
	assign sts.rem_last  = (rem_q == LW'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q     <= '0;
			fill_q   <= '0;
			lost_q   <= '0;
			rd_pos_q <= '0;
			rem_q    <= '0;
			valid_s1 <= 1'b0;
			byte_s1  <= 1'b0;
			last_s1  <= 1'b0;
		end else begin
			valid_s1 <= 1'b0;
			if (cmd.do_write) begin
				wp_q   <= wp_q + AW'(1);
				lost_q <= lost_q + obr_pkg::LOST_W'(source_lost)
					+ obr_pkg::LOST_W'(full);
				if (!full) begin
					fill_q <= fill_q + FW'(1);
				end
			end
			if (cmd.do_clear) begin
				wp_q   <= '0;
				fill_q <= '0;
				lost_q <= '0;
			end
			if (cmd.do_read_start) begin
				rd_pos_q <= wp_q - fill_q[AW-1:0];
				rem_q    <= n;
				fill_q   <= fill_q - FW'(n);
				lost_q   <= '0;
			end
			if (cmd.do_empty) begin
				valid_s1 <= 1'b1;
				byte_s1  <= 1'b0;
				last_s1  <= 1'b1;
			end
			if (cmd.do_issue) begin
				rd_pos_q <= rd_pos_q + AW'(1);
				rem_q    <= rem_q - LW'(1);
				valid_s1 <= 1'b1;
				byte_s1  <= 1'b1;
				last_s1  <= (rem_q == LW'(1));
			end
		end
	end

	// hold the counter as it stood when the read was taken
	always_ff @(posedge clk) begin
		if (cmd.do_read_start || cmd.do_empty) begin
			snap_q <= lost_q;
		end
	end

	obr_ram #(
		.WIDTH (obr_pkg::BYTE_W),
		.DEPTH (CAPACITY)
	) u_ram (
		.clk   (clk),
		.we    (cmd.do_write),
		.waddr (wp_q),
		.wdata (write_byte),
		.re    (cmd.do_issue),
		.raddr (rd_pos_q),
		.rdata (rdata)
	);

	assign strobe        = valid_s1;
	assign byte_valid    = byte_s1;
	assign last          = last_s1;
	assign read_byte     = byte_s1 ? rdata : '0;
	assign dropped_count = snap_q;

endmodule

`default_nettype wire

FILE: rtl/overwriting_byte_ring_buffer.sv
// Top level of the overwriting byte ring buffer: controller plus datapath.
// Depends on obr_pkg, obr_ctrl, obr_dpath (and obr_ram through it).
//
//  channel  | handshake          | fields
//  ---------+--------------------+---------------------------------------------------
//  item in  | start & !busy      | mode, write_byte, source_lost, read_limit
//  word out | strobe (one cycle) | read_byte, byte_valid, dropped_count, last
//
// A write or a clear produces no word. A read of an empty ring gives one word in
// the cycle after it is taken and busy stays low. A read that drains n bytes holds
// busy while it issues them, one RAM read port access per byte; each word appears
// in the cycle after its RAM read. Reset clears pointers, fill level and lost
// counter; RAM contents stay undefined. The receiver cannot stall the words.
`default_nettype none

module overwriting_byte_ring_buffer #(
	parameter int CAPACITY = 4096,
	parameter int MAX_READ = 64
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic [obr_pkg::MODE_W-1:0]    mode,
	input  wire logic [obr_pkg::BYTE_W-1:0]    write_byte,
	input  wire logic [obr_pkg::SRC_W-1:0]     source_lost,
	input  wire logic [obr_pkg::LIMIT_W-1:0]   read_limit,
	output logic                               strobe,
	output logic [obr_pkg::BYTE_W-1:0]         read_byte,
	output logic                               byte_valid,
	output logic [obr_pkg::LOST_W-1:0]         dropped_count,
	output logic                               last
);

	obr_pkg::cmd_t cmd;
	obr_pkg::sts_t sts;

	obr_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.mode   (mode),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	obr_dpath #(
		.CAPACITY (CAPACITY),
		.MAX_READ (MAX_READ)
	) u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.write_byte    (write_byte),
		.source_lost   (source_lost),
		.read_limit    (read_limit),
		.sts           (sts),
		.strobe        (strobe),
		.read_byte     (read_byte),
		.byte_valid    (byte_valid),
		.dropped_count (dropped_count),
		.last          (last)
	);

	a_empty_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !byte_valid |-> last)
		else $error("empty reply without last");

	a_end_gives_last: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> strobe && last)
		else $error("read ended without a final word");

	a_more_means_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last |-> busy)
		else $error("non-final word while sequencer idle");

	a_read_answers: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && mode == obr_pkg::MODE_READ |=> busy || strobe)
		else $error("read item produced nothing");

endmodule

`default_nettype wire
